>>> rtl/prs_pkg.sv
// Shared types and constants for the point and rectangle owner select block.
`default_nettype none

package prs_pkg;

    // Fixed widths of the transfer fields.
    localparam int COORD_BITS    = 20;
    localparam int SLOT_W        = 6;
    localparam int MARGIN_W      = 10;
    localparam int MAX_RECTS_DEF = 64;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(32);

    // Input transfer: a load of one table slot or a point query.
    typedef struct packed {
        logic                         req_type;
        logic [SLOT_W-1:0]            slot;
        logic                         has_box;
        logic signed [COORD_BITS-1:0] rect_left;
        logic signed [COORD_BITS-1:0] rect_bottom;
        logic signed [COORD_BITS-1:0] rect_right;
        logic signed [COORD_BITS-1:0] rect_top;
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
    } t_req;

    // Result transfer of one query.
    typedef struct packed {
        logic [SLOT_W-1:0] owner_index;
        logic              found;
        logic              by_containment;
    } t_res;

    // Request type codes as they arrive on the port.
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Command kinds after classification in the front end.
    typedef enum logic {
        CMD_LOAD,
        CMD_QUERY
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind kind;
        t_req      req;
    } t_cmd;

    // One rectangle table entry.
    typedef struct packed {
        logic                         valid;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] bottom;
        logic signed [COORD_BITS-1:0] right;
        logic signed [COORD_BITS-1:0] top;
    } t_entry;

    // Command queue status seen by the front end and the back end.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN
    } t_back_state;

endpackage

`default_nettype wire

>>> rtl/prs_front.sv
// Front end: accepts input transfers, classifies them and feeds the command queue.
`default_nettype none

module prs_front #(
    parameter int MAX_RECTS = prs_pkg::MAX_RECTS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire prs_pkg::t_req        i_req,
    input  wire logic                 i_ready,
    input  wire prs_pkg::t_q_status   i_q_status,
    output logic                      o_busy,
    output logic                      o_push,
    output prs_pkg::t_cmd             o_push_cmd
);

    logic          r_valid;
    prs_pkg::t_cmd r_cmd;
    logic          n_valid;
    logic          w_take;
    logic          w_keep;

    // The holding register drains into the queue whenever the queue has room.
    assign o_push     = r_valid && !i_q_status.full;
    assign o_push_cmd = r_cmd;
    assign o_busy     = !i_ready || (r_valid && i_q_status.full);
    assign w_take     = i_start && !o_busy;

    // Queries are always kept; loads that name a slot beyond the table are dropped.
    assign w_keep = (i_req.req_type == prs_pkg::REQ_QUERY) || (int'(i_req.slot) < MAX_RECTS);

    always_comb begin
        n_valid = r_valid;
        if (o_push) begin
            n_valid = 1'b0;
        end
        if (w_take && w_keep) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Classified command payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cmd.req  <= i_req;
            r_cmd.kind <= (i_req.req_type == prs_pkg::REQ_QUERY) ? prs_pkg::CMD_QUERY
                                                                 : prs_pkg::CMD_LOAD;
        end
    end

endmodule

`default_nettype wire

>>> rtl/prs_queue.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module prs_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire prs_pkg::t_cmd        i_push_cmd,
    input  wire logic                 i_pop,
    output prs_pkg::t_q_status        o_status,
    output prs_pkg::t_cmd             o_head
);

    prs_pkg::t_cmd r_ent [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_status.empty = (r_cnt == 2'd0);
    assign o_status.full  = (r_cnt == 2'd2);
    assign o_head         = r_ent[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wp] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/prs_back.sv
// Back end: rectangle table, clearing pass, loads and the pipelined query scan.
`default_nettype none

module prs_back #(
    parameter int MAX_RECTS = prs_pkg::MAX_RECTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [prs_pkg::MARGIN_W-1:0]  i_cfg_wdata,
    input  wire prs_pkg::t_q_status            i_q_status,
    input  wire prs_pkg::t_cmd                 i_q_head,
    output logic                               o_q_pop,
    output logic                               o_ready,
    output logic                               o_res_strobe,
    output prs_pkg::t_res                      o_res
);

    localparam int CB = prs_pkg::COORD_BITS;
    localparam int EW = CB + 2;
    localparam int GW = CB + 1;
    localparam int PW = 2 * GW;
    localparam int DW = PW + 1;
    localparam int AW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam logic [AW-1:0] LAST = AW'(MAX_RECTS - 1);

    // Sequencer.
    prs_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]        r_addr, n_addr;
    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    prs_pkg::t_entry      w_wdata;
    logic                 w_re;
    logic                 w_start_q;
    logic                 w_finish;

    // Table and margin.
    prs_pkg::t_entry           r_mem [MAX_RECTS];
    prs_pkg::t_entry           r_rd;
    logic [prs_pkg::MARGIN_W-1:0] r_margin;

    // Query point.
    logic signed [CB-1:0] r_px;
    logic signed [CB-1:0] r_py;

    // Scan pipeline: read data, geometry, products.
    logic          r_p1, r_p2, r_p3;
    logic [AW-1:0] r_idx1, r_idx2, r_idx3;
    logic          r_live2, r_live3;
    logic          r_in2, r_in3;
    logic [GW-1:0] r_spx2, r_spy2, r_gx2, r_gy2;
    logic [PW-1:0] r_area3, r_sx3, r_sy3;

    // Running winners.
    logic          r_have_c, r_have_n;
    logic [AW-1:0] r_best_c, r_best_n;
    logic [PW-1:0] r_best_area;
    logic [DW-1:0] r_best_d2;

    // Result register.
    logic          r_res_valid;
    prs_pkg::t_res r_res;

    assign o_ready      = (r_state != prs_pkg::BK_CLEAR);
    assign o_res_strobe = r_res_valid;
    assign o_res        = r_res;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prs_pkg::BK_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    // Next state and sequencer outputs.
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        o_q_pop   = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_addr;
        w_wdata   = '0;
        w_re      = 1'b0;
        w_start_q = 1'b0;
        w_finish  = 1'b0;
        case (r_state)
            prs_pkg::BK_CLEAR: begin
                w_we = 1'b1;
                if (r_addr == LAST) begin
                    n_state = prs_pkg::BK_IDLE;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            prs_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_head.kind == prs_pkg::CMD_LOAD) begin
                        w_we           = 1'b1;
                        w_waddr        = AW'(i_q_head.req.slot);
                        w_wdata.valid  = i_q_head.req.has_box;
                        w_wdata.left   = i_q_head.req.rect_left;
                        w_wdata.bottom = i_q_head.req.rect_bottom;
                        w_wdata.right  = i_q_head.req.rect_right;
                        w_wdata.top    = i_q_head.req.rect_top;
                    end else begin
                        w_start_q = 1'b1;
                        n_addr    = '0;
                        n_state   = prs_pkg::BK_SCAN;
                    end
                end
            end
            prs_pkg::BK_SCAN: begin
                w_re = 1'b1;
                if (r_addr == LAST) begin
                    n_state = prs_pkg::BK_DRAIN;
                    n_addr  = '0;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            prs_pkg::BK_DRAIN: begin
                if (!r_p1 && !r_p2 && !r_p3) begin
                    w_finish = 1'b1;
                    n_state  = prs_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = prs_pkg::BK_IDLE;
            end
        endcase
    end

    // Rectangle table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_mem[r_addr];
        end
    end

    // Margin register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= prs_pkg::MARGIN_RESET;
        end else if (i_cfg_we) begin
            r_margin <= i_cfg_wdata;
        end
    end

    // Query point capture.
    always_ff @(posedge i_clk) begin
        if (w_start_q) begin
            r_px <= i_q_head.req.point_x;
            r_py <= i_q_head.req.point_y;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
            r_p3 <= 1'b0;
        end else begin
            r_p1 <= w_re;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
        end
    end

    // Geometry of the entry just read: widened containment, spans and gaps.
    logic signed [EW-1:0] w_l, w_b, w_r, w_t, w_px, w_py, w_m;
    logic signed [EW-1:0] w_dx_span, w_dy_span;
    logic                 w_in;
    logic [GW-1:0]        w_spx, w_spy, w_gx, w_gy;

    assign w_l  = EW'(r_rd.left);
    assign w_b  = EW'(r_rd.bottom);
    assign w_r  = EW'(r_rd.right);
    assign w_t  = EW'(r_rd.top);
    assign w_px = EW'(r_px);
    assign w_py = EW'(r_py);
    assign w_m  = EW'(r_margin);

    assign w_in = (w_px >= w_l - w_m) && (w_px <= w_r + w_m) &&
                  (w_py >= w_b - w_m) && (w_py <= w_t + w_m);

    assign w_dx_span = w_r - w_l;
    assign w_dy_span = w_t - w_b;

    always_comb begin
        // An inverted side has zero length.
        w_spx = (w_dx_span > 0) ? w_dx_span[GW-1:0] : '0;
        w_spy = (w_dy_span > 0) ? w_dy_span[GW-1:0] : '0;
        w_gx  = '0;
        w_gy  = '0;
        if (w_px < w_l) begin
            w_gx = GW'(w_l - w_px);
        end else if (w_px > w_r) begin
            w_gx = GW'(w_px - w_r);
        end
        if (w_py < w_b) begin
            w_gy = GW'(w_b - w_py);
        end else if (w_py > w_t) begin
            w_gy = GW'(w_py - w_t);
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx1  <= r_addr;
        r_idx2  <= r_idx1;
        r_live2 <= r_rd.valid;
        r_in2   <= w_in;
        r_spx2  <= w_spx;
        r_spy2  <= w_spy;
        r_gx2   <= w_gx;
        r_gy2   <= w_gy;
    end

    // Products: area and squared gaps.
    logic [PW-1:0] w_area, w_sx, w_sy;

    assign w_area = r_spx2 * r_spy2;
    assign w_sx   = r_gx2 * r_gx2;
    assign w_sy   = r_gy2 * r_gy2;

    always_ff @(posedge i_clk) begin
        r_idx3  <= r_idx2;
        r_live3 <= r_live2;
        r_in3   <= r_in2;
        r_area3 <= w_area;
        r_sx3   <= w_sx;
        r_sy3   <= w_sy;
    end

    // Winner update; strict compares keep the lowest slot on ties.
    logic [DW-1:0] w_d2;
    logic          w_upd_c, w_upd_n;

    assign w_d2    = {1'b0, r_sx3} + {1'b0, r_sy3};
    assign w_upd_c = r_p3 && r_live3 && r_in3 && (!r_have_c || (r_area3 < r_best_area));
    assign w_upd_n = r_p3 && r_live3 && (!r_have_n || (w_d2 < r_best_d2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_c <= 1'b0;
            r_have_n <= 1'b0;
        end else if (w_start_q) begin
            r_have_c <= 1'b0;
            r_have_n <= 1'b0;
        end else begin
            if (w_upd_c) begin
                r_have_c <= 1'b1;
            end
            if (w_upd_n) begin
                r_have_n <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_c) begin
            r_best_c    <= r_idx3;
            r_best_area <= r_area3;
        end
        if (w_upd_n) begin
            r_best_n  <= r_idx3;
            r_best_d2 <= w_d2;
        end
    end

    // Result register, shown for one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= w_finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            if (r_have_c) begin
                r_res.owner_index    <= prs_pkg::SLOT_W'(r_best_c);
                r_res.found          <= 1'b1;
                r_res.by_containment <= 1'b1;
            end else if (r_have_n) begin
                r_res.owner_index    <= prs_pkg::SLOT_W'(r_best_n);
                r_res.found          <= 1'b1;
                r_res.by_containment <= 1'b0;
            end else begin
                r_res.owner_index    <= '0;
                r_res.found          <= 1'b0;
                r_res.by_containment <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/point_rect_owner_select.sv
// Top level of the point and rectangle owner select block.
//
// Usage:
//   Input channel: an item transfers at a rising edge with start high and busy
//   low. req_type selects a table load (slot, has_box, edges) or a point query.
//   Configuration: i_cfg_we with i_cfg_wdata writes the margin register; write it
//   only while no item is in flight.
//   Result channel: each query yields one result on o_res, marked by a
//   one-cycle o_res_strobe; the receiver cannot stall it. Loads yield nothing.
// Timing:
//   A front register and a two-entry command queue decouple accepts from the
//   back end, so a few items are taken while a query is still scanning.
//   A load is written to the table as it leaves the queue. A query scans the
//   table through the single read port of the rectangle memory, one slot a
//   cycle, then drains the read, geometry and product registers before the
//   result register is loaded.
// Reset:
//   Synchronous, active low. After reset a clearing pass writes every table
//   entry invalid with busy high; margin returns to 32.
`default_nettype none

module point_rect_owner_select #(
    parameter int MAX_RECTS = prs_pkg::MAX_RECTS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire prs_pkg::t_req                 i_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [prs_pkg::MARGIN_W-1:0]  i_cfg_wdata,
    output logic                               o_res_strobe,
    output prs_pkg::t_res                      o_res
);

    logic               w_push;
    prs_pkg::t_cmd      w_push_cmd;
    logic               w_pop;
    prs_pkg::t_q_status w_q_status;
    prs_pkg::t_cmd      w_q_head;
    logic               w_ready;

    // Accept and classify.
    prs_front #(
        .MAX_RECTS (MAX_RECTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .i_ready    (w_ready),
        .i_q_status (w_q_status),
        .o_busy     (busy),
        .o_push     (w_push),
        .o_push_cmd (w_push_cmd)
    );

    // Command queue.
    prs_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_status   (w_q_status),
        .o_head     (w_q_head)
    );

    // Table and scan engine.
    prs_back #(
        .MAX_RECTS (MAX_RECTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_q_status   (w_q_status),
        .i_q_head     (w_q_head),
        .o_q_pop      (w_pop),
        .o_ready      (w_ready),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

endmodule

`default_nettype wire

>>> rtl/prs_checker.sv
// Port-level checker for the owner select block and its bind statement.
`default_nettype none

module prs_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          busy,
    input wire logic          o_res_strobe,
    input wire prs_pkg::t_res o_res
);

    // Reset starts the clearing pass, so the block is busy right after it.
    a_busy_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> busy)
        else $error("busy low right after reset");

    // No result strobe follows a reset cycle.
    a_no_res_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_res_strobe)
        else $error("result strobe right after reset");

    // A query scans the whole table, so two results never come in adjacent cycles.
    a_res_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |=> !o_res_strobe)
        else $error("results in adjacent cycles");

    // An empty table gives slot zero and no containment.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && !o_res.found) |-> (o_res.owner_index == '0 && !o_res.by_containment))
        else $error("result without owner carries a slot or containment");

    // Containment implies an owner was found.
    a_contain_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.by_containment) |-> o_res.found)
        else $error("containment result without found");

endmodule

bind point_rect_owner_select prs_checker u_prs_checker (.*);

`default_nettype wire
